@@ design/k_step_max_walk_search_assert.svh @@
// Assertion macros for the walk search RTL.
`ifndef K_STEP_MAX_WALK_SEARCH_ASSERT_SVH
`define K_STEP_MAX_WALK_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KSW_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ksw_pkg.sv @@
// Types and constants shared by the walk search block.
`timescale 1ns / 1ps

package ksw_pkg;

	localparam int SRC_W      = 10;
	localparam int PTS_W      = 31;
	localparam int TARGET_W   = 48;
	localparam int STEPS_W    = 13;
	localparam int VCOUNT_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 2'd2;

	localparam logic [TARGET_W-1:0] TARGET_RST = 48'd1;
	localparam logic [STEPS_W-1:0]  STEPS_RST  = 13'd1;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 11'd1;

	typedef struct packed {
		logic [SRC_W-1:0] src;
		logic [SRC_W-1:0] dst;
		logic [PTS_W-1:0] pts;
	} ksw_edge_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_LAYER,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_CHK,
		ST_FIX_RD,
		ST_FIX_WR,
		ST_RES
	} ksw_state_t;

	typedef struct packed {
		logic clr;
		logic layer_start;
		logic edge_a;
		logic edge_b;
		logic fix_rd;
		logic fix_wr;
		logic bank;
	} ksw_dp_ctl_t;

	typedef struct packed {
		logic has0;
		logic hit;
	} ksw_dp_sts_t;

	typedef struct packed {
		logic               load;
		logic               reachable;
		logic [STEPS_W-1:0] min_steps;
	} ksw_res_t;

endpackage

@@ design/ksw_edge_if.sv @@
// Edge input channel.
`timescale 1ns / 1ps

interface ksw_edge_if
	import ksw_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SRC_W-1:0] edge_source;
	logic [SRC_W-1:0] edge_target;
	logic [PTS_W-1:0] edge_points;
	logic             last_edge;

	modport source (output valid, edge_source, edge_target, edge_points, last_edge,
		input ready);
	modport sink (input valid, edge_source, edge_target, edge_points, last_edge,
		output ready);
endinterface

@@ design/ksw_result_if.sv @@
// Result output channel.
`timescale 1ns / 1ps

interface ksw_result_if
	import ksw_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               reachable;
	logic [STEPS_W-1:0] min_steps;

	modport source (output valid, reachable, min_steps, input ready);
	modport sink (input valid, reachable, min_steps, output ready);
endinterface

@@ design/ksw_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps

interface ksw_cfg_if
	import ksw_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/ksw_edge_mem.sv @@
// Edge store: one write port, one registered read port.
`timescale 1ns / 1ps

module ksw_edge_mem
	import ksw_pkg::*;
#(
	parameter int MAX_EDGES = 4096
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] wa,
	input  ksw_edge_t                                       wd,
	input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] ra,
	output ksw_edge_t                                       rd
);

	ksw_edge_t mem [MAX_EDGES];
	ksw_edge_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;

endmodule

@@ design/ksw_score_dp.sv @@
// Score banks, out-edge flags and the shared add, saturate and compare unit.
`timescale 1ns / 1ps

module ksw_score_dp
	import ksw_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int SCORE_BITS   = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ksw_dp_ctl_t                            ctl,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]      nv,
	input  logic [$clog2(MAX_VERTICES)-1:0]        sweep_v,
	input  ksw_edge_t                              edge_rd,
	input  logic [TARGET_W-1:0]                    target,
	output ksw_dp_sts_t                            sts
);

	localparam int VW     = $clog2(MAX_VERTICES + 1);
	localparam int VA     = $clog2(MAX_VERTICES);
	localparam int CMP_W  = (VW > VCOUNT_W) ? VW : VCOUNT_W;
	localparam int SUM_W  = SCORE_BITS + 1;
	localparam int SCMP_W = (SCORE_BITS > TARGET_W) ? SCORE_BITS : TARGET_W;
	localparam logic [SCORE_BITS-1:0] SCORE_CAP = '1;

	logic [SCORE_BITS-1:0] bank0_mem [MAX_VERTICES];
	logic [SCORE_BITS-1:0] bank1_mem [MAX_VERTICES];
	logic                  has_out_mem [MAX_VERTICES];

	logic [SCORE_BITS-1:0] bank0_rd_q;
	logic [SCORE_BITS-1:0] bank1_rd_q;
	logic                  ho_rd_q;
	logic [VA-1:0]         src_q;
	logic [PTS_W-1:0]      pts_q;
	logic                  valid_q;
	logic                  has0_q;
	logic [SCORE_BITS-1:0] best0_q;

	logic [CMP_W-1:0]      src_ext;
	logic [CMP_W-1:0]      dst_ext;
	logic [VA-1:0]         src_a;
	logic [VA-1:0]         dst_a;
	logic                  edge_ok;
	logic [SCORE_BITS-1:0] prev_val;
	logic [SCORE_BITS-1:0] cur_val;
	logic [SUM_W-1:0]      sum;
	logic [SCORE_BITS-1:0] cand;
	logic                  upd;
	logic                  fix_we;

	logic                  b0_we;
	logic                  b1_we;
	logic [VA-1:0]         b0_wa;
	logic [VA-1:0]         b1_wa;
	logic [SCORE_BITS-1:0] b0_wd;
	logic [SCORE_BITS-1:0] b1_wd;
	logic [VA-1:0]         b0_ra;
	logic [VA-1:0]         b1_ra;

	// Edges touching a vertex outside the graph are ignored.
	assign src_ext = CMP_W'(edge_rd.src);
	assign dst_ext = CMP_W'(edge_rd.dst);
	assign src_a   = src_ext[VA-1:0];
	assign dst_a   = dst_ext[VA-1:0];
	assign edge_ok = (src_ext < CMP_W'(nv)) && (dst_ext < CMP_W'(nv));

	// bank set: current layer bank, clear: current layer is bank 0.
	assign prev_val = ctl.bank ? bank0_rd_q : bank1_rd_q;
	assign cur_val  = ctl.bank ? bank1_rd_q : bank0_rd_q;
	assign sum      = SUM_W'(prev_val) + SUM_W'(pts_q);
	assign cand     = sum[SCORE_BITS] ? SCORE_CAP : sum[SCORE_BITS-1:0];
	assign upd      = valid_q && (cand > cur_val);
	assign fix_we   = (sweep_v != '0) && !ho_rd_q;

	always_comb begin
		b0_we = 1'b0;
		b1_we = 1'b0;
		b0_wa = sweep_v;
		b1_wa = sweep_v;
		b0_wd = '0;
		b1_wd = '0;
		b0_ra = ctl.bank ? dst_a : src_a;
		b1_ra = ctl.bank ? src_a : dst_a;
		if (ctl.clr) begin
			b0_we = 1'b1;
			b1_we = 1'b1;
		end else if (ctl.edge_b) begin
			if (ctl.bank) begin
				b1_we = upd;
				b1_wa = src_q;
				b1_wd = cand;
			end else begin
				b0_we = upd;
				b0_wa = src_q;
				b0_wd = cand;
			end
		end else if (ctl.fix_wr) begin
			// Borrow vertex 0's score, and zero the bank the next layer fills.
			if (ctl.bank) begin
				b1_we = fix_we;
				b1_wd = best0_q;
				b0_we = 1'b1;
			end else begin
				b0_we = fix_we;
				b0_wd = best0_q;
				b1_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b0_we) begin
			bank0_mem[b0_wa] <= b0_wd;
		end
		if (ctl.edge_a) begin
			bank0_rd_q <= bank0_mem[b0_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (b1_we) begin
			bank1_mem[b1_wa] <= b1_wd;
		end
		if (ctl.edge_a) begin
			bank1_rd_q <= bank1_mem[b1_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			has_out_mem[sweep_v] <= 1'b0;
		end else if (ctl.edge_a && edge_ok) begin
			has_out_mem[src_a] <= 1'b1;
		end
		if (ctl.fix_rd) begin
			ho_rd_q <= has_out_mem[sweep_v];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.edge_a) begin
			src_q   <= src_a;
			pts_q   <= edge_rd.pts;
			valid_q <= edge_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has0_q  <= 1'b0;
			best0_q <= '0;
		end else begin
			if (ctl.clr) begin
				has0_q <= 1'b0;
			end else if (ctl.edge_a && edge_ok && (src_a == '0)) begin
				has0_q <= 1'b1;
			end
			if (ctl.layer_start) begin
				best0_q <= '0;
			end else if (ctl.edge_b && upd && (src_q == '0)) begin
				best0_q <= cand;
			end
		end
	end

	assign sts.has0 = has0_q;
	assign sts.hit  = SCMP_W'(best0_q) >= SCMP_W'(target);

endmodule

@@ design/ksw_seq.sv @@
// Search sequencer: sweeps, edge passes per layer and result decision.
`timescale 1ns / 1ps
`include "k_step_max_walk_search_assert.svh"

module ksw_seq
	import ksw_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096,
	parameter int MAX_STEPS    = 4096
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                start,
	input  logic [$clog2(MAX_EDGES+1)-1:0]                      total,
	input  logic [VCOUNT_W-1:0]                                 vertex_count,
	input  logic [STEPS_W-1:0]                                  max_steps,
	input  logic                                                res_free,
	input  ksw_dp_sts_t                                         sts,
	output ksw_dp_ctl_t                                         ctl,
	output logic [$clog2(MAX_VERTICES+1)-1:0]                   nv,
	output logic [$clog2(MAX_VERTICES)-1:0]                     sweep_v,
	output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] edge_ra,
	output logic                                                idle,
	output ksw_res_t                                            res
);

	localparam int VW     = $clog2(MAX_VERTICES + 1);
	localparam int VA     = $clog2(MAX_VERTICES);
	localparam int EW     = $clog2(MAX_EDGES + 1);
	localparam int EA     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int SW     = $clog2(MAX_STEPS + 1);
	localparam int VCMP_W = (VW > VCOUNT_W) ? VW : VCOUNT_W;
	localparam int SCMP_W = (SW > STEPS_W) ? SW : STEPS_W;

	ksw_state_t         state_q;
	ksw_state_t         state_d;
	logic [VW-1:0]      v_q;
	logic [VW-1:0]      v_d;
	logic [EW-1:0]      e_q;
	logic [EW-1:0]      e_d;
	logic [SW-1:0]      j_q;
	logic [SW-1:0]      j_d;
	logic [VW-1:0]      nv_q;
	logic [VW-1:0]      nv_d;
	logic [SW-1:0]      steps_q;
	logic [SW-1:0]      steps_d;
	logic               bank_q;
	logic               bank_d;
	logic               reach_q;
	logic               reach_d;
	logic [STEPS_W-1:0] min_q;
	logic [STEPS_W-1:0] min_d;
	logic               res_load;

	logic [VCMP_W-1:0]  vc_ext;
	logic [VW-1:0]      nv_clamp;
	logic [SCMP_W-1:0]  ms_ext;
	logic [SW-1:0]      steps_clamp;
	logic [VW-1:0]      v_nxt;
	logic               v_last;
	logic [EW-1:0]      e_nxt;

	// Zero vertices act as one, and both limits saturate at the build maximum.
	assign vc_ext   = VCMP_W'(vertex_count);
	assign nv_clamp = (vc_ext == '0) ? VW'(1) :
		(vc_ext > VCMP_W'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vc_ext[VW-1:0];
	assign ms_ext      = SCMP_W'(max_steps);
	assign steps_clamp = (ms_ext > SCMP_W'(MAX_STEPS)) ? SW'(MAX_STEPS) : ms_ext[SW-1:0];

	assign v_nxt  = v_q + VW'(1);
	assign v_last = (v_nxt == nv_q);
	assign e_nxt  = e_q + EW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q     <= '0;
			e_q     <= '0;
			j_q     <= '0;
			nv_q    <= VW'(1);
			steps_q <= '0;
			bank_q  <= 1'b0;
			reach_q <= 1'b0;
			min_q   <= '0;
		end else begin
			state_q <= state_d;
			v_q     <= v_d;
			e_q     <= e_d;
			j_q     <= j_d;
			nv_q    <= nv_d;
			steps_q <= steps_d;
			bank_q  <= bank_d;
			reach_q <= reach_d;
			min_q   <= min_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		v_d      = v_q;
		e_d      = e_q;
		j_d      = j_q;
		nv_d     = nv_q;
		steps_d  = steps_q;
		bank_d   = bank_q;
		reach_d  = reach_q;
		min_d    = min_q;
		res_load = 1'b0;
		ctl      = '0;
		ctl.bank = bank_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					nv_d    = nv_clamp;
					steps_d = steps_clamp;
					v_d     = '0;
					e_d     = '0;
					bank_d  = 1'b0;
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				ctl.clr = 1'b1;
				if (v_last) begin
					if (steps_q == '0) begin
						reach_d = 1'b0;
						min_d   = '0;
						state_d = ST_RES;
					end else begin
						j_d     = SW'(1);
						e_d     = '0;
						state_d = ST_LAYER;
					end
				end else begin
					v_d = v_nxt;
				end
			end
			ST_LAYER: begin
				ctl.layer_start = 1'b1;
				state_d         = ST_EDGE_A;
			end
			ST_EDGE_A: begin
				ctl.edge_a = 1'b1;
				state_d    = ST_EDGE_B;
			end
			ST_EDGE_B: begin
				ctl.edge_b = 1'b1;
				if (e_nxt == total) begin
					state_d = ST_CHK;
				end else begin
					e_d     = e_nxt;
					state_d = ST_EDGE_A;
				end
			end
			ST_CHK: begin
				if (!sts.has0) begin
					reach_d = 1'b0;
					min_d   = '0;
					state_d = ST_RES;
				end else if (sts.hit) begin
					reach_d = 1'b1;
					min_d   = STEPS_W'(j_q);
					state_d = ST_RES;
				end else if (j_q == steps_q) begin
					reach_d = 1'b0;
					min_d   = '0;
					state_d = ST_RES;
				end else begin
					v_d     = '0;
					state_d = ST_FIX_RD;
				end
			end
			ST_FIX_RD: begin
				ctl.fix_rd = 1'b1;
				state_d    = ST_FIX_WR;
			end
			ST_FIX_WR: begin
				ctl.fix_wr = 1'b1;
				if (v_last) begin
					j_d     = j_q + SW'(1);
					bank_d  = !bank_q;
					e_d     = '0;
					state_d = ST_LAYER;
				end else begin
					v_d     = v_nxt;
					state_d = ST_FIX_RD;
				end
			end
			ST_RES: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Fetch the next edge while the current one updates its score.
	assign edge_ra = (state_q == ST_EDGE_B) ? e_nxt[EA-1:0] : e_q[EA-1:0];
	assign sweep_v = v_q[VA-1:0];
	assign nv      = nv_q;
	assign idle    = (state_q == ST_IDLE);

	assign res.load      = res_load;
	assign res.reachable = reach_q;
	assign res.min_steps = min_q;

	`KSW_ASSERT_NEXT(a_start_leaves_idle, (state_q == ST_IDLE) && start, state_q == ST_CLR, "search start did not begin the clearing sweep")
	`KSW_ASSERT(a_sweep_in_range, (state_q == ST_CLR) || (state_q == ST_FIX_RD) || (state_q == ST_FIX_WR), v_q < nv_q, "vertex sweep ran past the vertex count")
	`KSW_ASSERT(a_edge_in_range, (state_q == ST_EDGE_A) || (state_q == ST_EDGE_B), e_q < total, "edge pass ran past the stored edges")
	`KSW_ASSERT(a_layer_in_range, state_q == ST_EDGE_A, (j_q > 0) && (j_q <= steps_q), "layer number outside one to the step limit")

endmodule

@@ design/k_step_max_walk_search.sv @@
// Throughput: edges are taken one item a cycle; a last edge starts the search and
//   holds ready low until its result is in the output register.
// Search: a clearing sweep of the N vertices, then per layer one pass of the E stored
//   edges through the shared score adder and, between layers, a sweep of the N vertices.
// Reset (arst_n low, asynchronous): registers back to 1, no edges stored, no result.
`timescale 1ns / 1ps

module k_step_max_walk_search
	import ksw_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096,
	parameter int MAX_STEPS    = 4096,
	parameter int SCORE_BITS   = 48
) (
	input logic          clk,
	input logic          arst_n,
	ksw_edge_if.sink     edges,
	ksw_result_if.source results,
	ksw_cfg_if.sink      cfg
);

	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int VA = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	// Configuration registers.
	logic [TARGET_W-1:0] target_q;
	logic [STEPS_W-1:0]  max_steps_q;
	logic [VCOUNT_W-1:0] vcount_q;

	// Edge loading.
	logic [EW-1:0]       edge_total_q;
	logic                edge_acc;
	logic                edge_we;
	logic                start;
	ksw_edge_t           edge_wd;
	ksw_edge_t           edge_rd;
	logic [EA-1:0]       edge_ra;

	// Sequencer and datapath links.
	logic                seq_idle;
	logic                res_free;
	ksw_res_t            res;
	ksw_dp_ctl_t         ctl;
	ksw_dp_sts_t         sts;
	logic [VW-1:0]       nv;
	logic [VA-1:0]       sweep_v;

	// Result register.
	logic                out_valid_q;
	logic                out_reach_q;
	logic [STEPS_W-1:0]  out_steps_q;

	// The user sends writes only while the block is idle; the block does not check and always takes them.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TARGET_RST;
			max_steps_q <= STEPS_RST;
			vcount_q    <= VCOUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TARGET: target_q    <= cfg.data[TARGET_W-1:0];
				REG_STEPS:  max_steps_q <= cfg.data[STEPS_W-1:0];
				REG_VCOUNT: vcount_q    <= cfg.data[VCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Take edges only while no search runs. Drop an edge once the store is full;
	// a dropped last edge still starts the search.
	assign edges.ready = seq_idle;
	assign edge_acc    = edges.valid && edges.ready;
	assign edge_we     = edge_acc && (edge_total_q < EW'(MAX_EDGES));
	assign start       = edge_acc && edges.last_edge;

	assign edge_wd.src = edges.edge_source;
	assign edge_wd.dst = edges.edge_target;
	assign edge_wd.pts = edges.edge_points;

	// Empty the graph as the result leaves for the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
		end else if (res.load) begin
			edge_total_q <= '0;
		end else if (edge_we) begin
			edge_total_q <= edge_total_q + EW'(1);
		end
	end

	ksw_edge_mem #(
		.MAX_EDGES (MAX_EDGES)
	) u_edge_mem (
		.clk (clk),
		.we  (edge_we),
		.wa  (edge_total_q[EA-1:0]),
		.wd  (edge_wd),
		.ra  (edge_ra),
		.rd  (edge_rd)
	);

	ksw_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.MAX_STEPS    (MAX_STEPS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.total        (edge_total_q),
		.vertex_count (vcount_q),
		.max_steps    (max_steps_q),
		.res_free     (res_free),
		.sts          (sts),
		.ctl          (ctl),
		.nv           (nv),
		.sweep_v      (sweep_v),
		.edge_ra      (edge_ra),
		.idle         (seq_idle),
		.res          (res)
	);

	ksw_score_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.SCORE_BITS   (SCORE_BITS)
	) u_score_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.nv      (nv),
		.sweep_v (sweep_v),
		.edge_rd (edge_rd),
		.target  (target_q),
		.sts     (sts)
	);

	// Hold the result until taken; a new result may load as the old one leaves.
	assign res_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			out_reach_q <= res.reachable;
			out_steps_q <= res.min_steps;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.reachable = out_reach_q;
	assign results.min_steps = out_steps_q;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the k-step max walk search block.
`timescale 1ns / 1ps

module testbench;
	import ksw_pkg::*;

	// Sizes of the block as built with its default parameters.
	localparam int VTX_LIMIT  = 1024;
	localparam int ARC_LIMIT  = 4096;
	localparam int STEP_LIMIT = 4096;
	localparam int SCORE_W    = 48;
	localparam longint unsigned SCORE_CAP = (64'd1 << SCORE_W) - 64'd1;

	localparam int unsigned     PTS_TOP    = 32'h7FFF_FFFF;
	localparam longint unsigned TARGET_TOP = 64'hFFFF_FFFF_FFFF;

	// Random edge items before the last part, and the length of the last part.
	localparam int unsigned RANDOM_ARCS = 1600;
	localparam int unsigned CALM_ARCS   = 150;
	// Cycles to let pass once the last result is in, before touching a register.
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct packed {
		ksw_edge_t arc;
		logic      last;
	} arc_item_t;

	typedef struct packed {
		logic               reachable;
		logic [STEPS_W-1:0] min_steps;
	} walk_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ksw_edge_if   edge_ch ();
	ksw_result_if res_ch ();
	ksw_cfg_if    cfg_ch ();

	k_step_max_walk_search u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.edges   (edge_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	always #5 clk = ~clk;

	// Graph and register copy held by the predictor.
	logic [SRC_W-1:0]    graph_src [ARC_LIMIT];
	logic [SRC_W-1:0]    graph_dst [ARC_LIMIT];
	logic [PTS_W-1:0]    graph_pts [ARC_LIMIT];
	int unsigned         graph_arcs = 0;
	logic [TARGET_W-1:0] want_score = TARGET_RST;
	logic [STEPS_W-1:0]  step_reg   = STEPS_RST;
	logic [VCOUNT_W-1:0] vtx_reg    = VCOUNT_RST;

	// Per-layer scratch for the predictor.
	bit              fans_out   [VTX_LIMIT];
	longint unsigned layer_prev [VTX_LIMIT];
	longint unsigned layer_cur  [VTX_LIMIT];

	arc_item_t    arc_pending [$];
	walk_answer_t answers_due [$];

	bit          idling_on = 1'b0;
	logic        arc_accepted = 1'b0;
	int unsigned arc_gap = 0;
	int unsigned ans_gap = 0;
	int unsigned arcs_queued = 0;
	int unsigned arcs_taken = 0;
	int unsigned regs_written = 0;
	int unsigned fault_count = 0;
	int unsigned searches_done = 0;
	int unsigned reachable_seen = 0;
	int unsigned deepest_walk = 0;

	longint unsigned cycle_count = 0;
	longint unsigned work_budget = 0;

	// Least layer at which vertex 0 meets the target, 0 when none does.
	// Also books the cycles the block needs for this search.
	function automatic int unsigned first_hit_layer();
		int unsigned nv;
		int unsigned steps;
		int unsigned v;
		int unsigned e;
		int unsigned j;
		longint unsigned cand;
		nv = 32'(vtx_reg);
		if (nv == 0) nv = 1;
		if (nv > VTX_LIMIT) nv = VTX_LIMIT;
		steps = 32'(step_reg);
		if (steps > STEP_LIMIT) steps = STEP_LIMIT;
		work_budget += nv + 2 * graph_arcs + 16;

		// Edges with an end outside the graph take no part at all.
		for (v = 0; v < VTX_LIMIT; v++) fans_out[v] = 1'b0;
		for (e = 0; e < graph_arcs; e++) begin
			if (graph_src[e] < nv && graph_dst[e] < nv) fans_out[graph_src[e]] = 1'b1;
		end
		if (!fans_out[0]) return 0;

		for (v = 0; v < nv; v++) layer_prev[v] = 0;
		for (j = 1; j <= steps; j++) begin
			work_budget += 2 * graph_arcs + 3 + 2 * nv;
			for (v = 0; v < nv; v++) layer_cur[v] = 0;
			for (e = 0; e < graph_arcs; e++) begin
				if (graph_src[e] < nv && graph_dst[e] < nv) begin
					cand = longint'(graph_pts[e]) + layer_prev[graph_dst[e]];
					if (cand > SCORE_CAP) cand = SCORE_CAP;
					if (cand > layer_cur[graph_src[e]]) layer_cur[graph_src[e]] = cand;
				end
			end
			// Dead ends borrow vertex 0's edges, hence its score.
			for (v = 1; v < nv; v++) begin
				if (!fans_out[v]) layer_cur[v] = layer_cur[0];
			end
			if (layer_cur[0] >= {16'd0, want_score}) return j;
			for (v = 0; v < nv; v++) layer_prev[v] = layer_cur[v];
		end
		return 0;
	endfunction

	// Store one accepted edge; a last edge runs the search and empties the graph.
	function automatic void take_arc(input arc_item_t it);
		walk_answer_t ans;
		int unsigned hit;
		work_budget += 32;
		if (graph_arcs < ARC_LIMIT) begin
			graph_src[graph_arcs] = it.arc.src;
			graph_dst[graph_arcs] = it.arc.dst;
			graph_pts[graph_arcs] = it.arc.pts;
			graph_arcs++;
		end
		if (it.last) begin
			hit = first_hit_layer();
			ans.reachable = (hit != 0);
			ans.min_steps = hit[STEPS_W-1:0];
			answers_due = {answers_due, ans};
			graph_arcs = 0;
		end
	endfunction

	// Compare one delivered result against the oldest answer waiting.
	function automatic void check_answer();
		walk_answer_t due;
		if (answers_due.size() == 0) begin
			$error("result with no answer waiting: reachable %0d, min_steps %0d",
				res_ch.reachable, res_ch.min_steps);
			fault_count++;
			return;
		end
		due = answers_due.pop_front();
		searches_done++;
		if (due.reachable) reachable_seen++;
		if (32'(due.min_steps) > deepest_walk) deepest_walk = 32'(due.min_steps);
		if (res_ch.reachable !== due.reachable) begin
			$error("reachable: expected %0d, actual %0d", due.reachable, res_ch.reachable);
			fault_count++;
		end
		if (res_ch.min_steps !== due.min_steps) begin
			$error("min_steps: expected %0d, actual %0d", due.min_steps, res_ch.min_steps);
			fault_count++;
		end
	endfunction

	// Monitor: everything that moves is seen at the rising edge.
	always @(posedge clk) begin
		arc_item_t seen;
		if (!arst_n) begin
			arc_accepted <= 1'b0;
		end else begin
			arc_accepted <= edge_ch.valid && edge_ch.ready;
			// Register writes land in the predictor's copy as the block takes them.
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_TARGET: want_score = cfg_ch.data[TARGET_W-1:0];
					REG_STEPS:  step_reg = cfg_ch.data[STEPS_W-1:0];
					REG_VCOUNT: vtx_reg = cfg_ch.data[VCOUNT_W-1:0];
					default: ;
				endcase
				regs_written++;
			end
			if (res_ch.valid && res_ch.ready) check_answer();
			if (edge_ch.valid && edge_ch.ready) begin
				seen.arc.src = edge_ch.edge_source;
				seen.arc.dst = edge_ch.edge_target;
				seen.arc.pts = edge_ch.edge_points;
				seen.last = edge_ch.last_edge;
				take_arc(seen);
				arcs_taken++;
			end
		end
	end

	// Driver: feed edge items from the pending queue, with random idle bursts.
	always @(negedge clk) begin
		arc_item_t nxt;
		if (!arst_n) begin
			edge_ch.valid <= 1'b0;
		end else if (edge_ch.valid && !arc_accepted) begin
			// hold the item until the block takes it
		end else if (arc_gap != 0) begin
			edge_ch.valid <= 1'b0;
			arc_gap--;
		end else if (idling_on && arc_pending.size() != 0 && $urandom_range(0, 9) == 0) begin
			edge_ch.valid <= 1'b0;
			arc_gap = $urandom_range(0, 13);
		end else if (arc_pending.size() != 0) begin
			nxt = arc_pending.pop_front();
			edge_ch.valid <= 1'b1;
			edge_ch.edge_source <= nxt.arc.src;
			edge_ch.edge_target <= nxt.arc.dst;
			edge_ch.edge_points <= nxt.arc.pts;
			edge_ch.last_edge <= nxt.last;
		end else begin
			edge_ch.valid <= 1'b0;
		end
	end

	// Result side: ready high except for random stall bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (ans_gap != 0) begin
			res_ch.ready <= 1'b0;
			ans_gap--;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			res_ch.ready <= 1'b0;
			ans_gap = $urandom_range(0, 13);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog: the allowance grows with the work the predictor has booked.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd200000 + 4 * work_budget) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic put_arc(input int unsigned src, input int unsigned dst,
			input int unsigned pts, input bit last);
		arc_item_t it;
		it.arc.src = SRC_W'(src);
		it.arc.dst = SRC_W'(dst);
		it.arc.pts = PTS_W'(pts);
		it.last = last;
		arc_pending = {arc_pending, it};
		arcs_queued++;
	endtask

	// Wait until every item is in and every answer out, then let the block settle.
	task automatic quiesce();
		while (arcs_taken != arcs_queued || answers_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		int unsigned before_count;
		before_count = regs_written;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(negedge clk); while (regs_written == before_count);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic program_regs(input longint unsigned tgt,
			input int unsigned steps, input int unsigned vc);
		write_reg(REG_TARGET, CFG_DATA_W'(tgt));
		write_reg(REG_STEPS, CFG_DATA_W'(STEPS_W'(steps)));
		write_reg(REG_VCOUNT, CFG_DATA_W'(VCOUNT_W'(vc)));
	endtask

	// One graph of random edges. The first and about a quarter of the rest leave vertex 0
	// so the search gets going; a broken graph does not force that, and a few edges are pure noise.
	task automatic queue_graph(input int unsigned n_arcs, input int unsigned nv,
			input int unsigned pts_hi, input bit broken);
		int unsigned k;
		int unsigned roll;
		int unsigned src;
		int unsigned dst;
		int unsigned pts;
		for (k = 0; k < n_arcs; k++) begin
			roll = $urandom_range(0, 19);
			if (roll == 0) src = $urandom;
			else if (!broken && (k == 0 || roll < 6)) src = 0;
			else if (broken && nv > 1) src = $urandom_range(1, nv - 1);
			else src = $urandom_range(0, nv - 1);
			dst = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, nv - 1);
			pts = ($urandom_range(0, 7) == 0) ? pts_hi : $urandom_range(0, pts_hi);
			put_arc(src, dst, pts, k == n_arcs - 1);
		end
	endtask

	initial begin
		int unsigned random_arcs;
		int unsigned calm_arcs;
		int unsigned kind;
		int unsigned nv;
		int unsigned steps_eff;
		int unsigned arcs_hi;
		int unsigned pts_hi;
		int unsigned n;
		int unsigned vc;
		int unsigned steps;
		longint unsigned tgt;

		// Drive every input to a known value from time zero.
		edge_ch.valid = 1'b0;
		edge_ch.edge_source = '0;
		edge_ch.edge_target = '0;
		edge_ch.edge_points = '0;
		edge_ch.last_edge = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TARGET;
		cfg_ch.data = '0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Registers at their reset values: a zero-score loop misses a target of 1,
		// a one-point loop meets it in one step.
		put_arc(0, 0, 0, 1'b1);
		put_arc(0, 0, 1, 1'b1);
		quiesce();

		// Target zero; first a graph where vertex 0 has no out-edge at all.
		program_regs(0, 3, 4);
		put_arc(1, 2, 5, 1'b1);
		put_arc(0, 1, 0, 1'b1);
		quiesce();

		// Step limit above the maximum; edges outside the graph; vertex 2 is a
		// dead end and borrows vertex 0's edges.
		program_regs(100, '1, 3);
		put_arc(5, 0, PTS_TOP, 1'b0);
		put_arc(0, 7, PTS_TOP, 1'b0);
		put_arc(0, 2, 1, 1'b0);
		put_arc(0, 1, 30, 1'b0);
		put_arc(1, 0, 20, 1'b1);
		quiesce();

		// Step limit zero: no layer runs, so nothing is reachable.
		program_regs(PTS_TOP, 0, 2);
		put_arc(0, 1, PTS_TOP, 1'b0);
		put_arc(1, 0, PTS_TOP, 1'b1);
		quiesce();

		// Vertex count zero acts as one; the edge to vertex 1 drops out.
		program_regs(PTS_TOP, 1, 0);
		put_arc(0, 0, PTS_TOP, 1'b0);
		put_arc(0, 1, PTS_TOP, 1'b1);
		quiesce();

		// Vertex count above the maximum, all-ones target, highest vertex numbers.
		program_regs(TARGET_TOP, 2, '1);
		put_arc(1023, 0, PTS_TOP, 1'b0);
		put_arc(0, 1023, PTS_TOP, 1'b1);
		quiesce();

		// Deepest walk: the target is met exactly at the largest step count.
		program_regs(longint'(PTS_TOP) * STEP_LIMIT, STEP_LIMIT, 1);
		put_arc(0, 0, PTS_TOP, 1'b1);
		quiesce();

		// Random phases, each with fresh register values and a batch of graphs.
		random_arcs = 0;
		while (random_arcs < RANDOM_ARCS) begin
			quiesce();
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				// Full-size vertex range, only a few layers to keep it quick.
				vc = ($urandom_range(0, 1) != 0) ? VTX_LIMIT :
					$urandom_range(VTX_LIMIT + 1, 2047);
				steps = $urandom_range(1, 3);
				arcs_hi = 24;
			end else if (kind == 1) begin
				// Long walks over a tiny graph.
				vc = $urandom_range(1, 4);
				steps = $urandom_range(64, 300);
				arcs_hi = 6;
			end else begin
				vc = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
				steps = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
				arcs_hi = 14;
			end
			nv = (vc == 0) ? 1 : ((vc > VTX_LIMIT) ? VTX_LIMIT : vc);
			steps_eff = steps;
			case ($urandom_range(0, 3))
				0: pts_hi = 3;
				1: pts_hi = 255;
				2: pts_hi = 65535;
				default: pts_hi = PTS_TOP;
			endcase
			case ($urandom_range(0, 7))
				0: tgt = 0;
				1: tgt = TARGET_TOP;
				default: tgt = longint'($urandom_range(0, pts_hi)) *
					longint'($urandom_range(1, steps_eff + 2));
			endcase
			program_regs(tgt, steps, vc);
			idling_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 12)) begin
				n = $urandom_range(1, arcs_hi);
				queue_graph(n, nv, pts_hi, $urandom_range(0, 9) == 0);
				random_arcs += n;
			end
		end

		// Last part: small graphs at full rate, no idling on either side.
		quiesce();
		program_regs(longint'($urandom_range(0, 2000)), $urandom_range(1, 24),
			$urandom_range(1, 16));
		idling_on = 1'b0;
		calm_arcs = 0;
		while (calm_arcs < CALM_ARCS) begin
			n = $urandom_range(1, 12);
			queue_graph(n, 32'(vtx_reg), 255, 1'b0);
			calm_arcs += n;
		end
		quiesce();

		$display("summary: %0d edge items, %0d searches checked, %0d reachable",
			arcs_taken, searches_done, reachable_seen);
		$display("summary: deepest walk %0d steps, %0d register writes, %0d mismatches",
			deepest_walk, regs_written, fault_count);
		if (fault_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
